/* hdl/mm2_pkg.sv */
package mm2_pkg;

    localparam logic [31:0] MUL    = 32'h5bd1e995;
    localparam int unsigned SHR_R  = 24;
    localparam int unsigned SHR_F1 = 13;
    localparam int unsigned SHR_F2 = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_H1,
        ST_TAIL,
        ST_AVAL,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_KEY,
        OP_HASH,
        OP_TAIL,
        OP_AVAL
    } t_mul_op;

endpackage

/* hdl/murmur2_byte_stream_hash.sv */
// Streaming 32-bit MurmurHash2, seed zero, one message byte per input word.
// A word with i_first loads the hash with i_msg_len; a word with i_last ends
// the message and yields one o_hash. All multiplies by 0x5bd1e995 go through a
// single shared 32-bit multiplier under a small sequencer, so the cost is set
// by how many multiplies a word needs: none for a byte that does not
// complete a four-byte group, three for a byte that completes one, plus the
// tail and avalanche multiplies and the output load on a last word. The block
// takes a new word while a finished hash still waits in the output register;
// it stalls while the sequencer runs its multiplies, and when a second hash
// is ready before the first is taken.
module murmur2_byte_stream_hash (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic [31:0] i_msg_len,
    input  logic        i_first,
    input  logic        i_last,
    input  logic        i_empty_msg,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_hash
);

    mm2_pkg::t_state  r_state, n_state;
    mm2_pkg::t_mul_op w_op;

    logic [31:0] r_h, n_h;
    logic [31:0] r_k, n_k;
    logic [23:0] r_wb, n_wb;
    logic [1:0]  r_pos, n_pos;
    logic        r_last, n_last;
    logic        r_out_valid, n_out_valid;
    logic [31:0] r_hash, n_hash;

    logic [31:0] w_prod;
    logic [31:0] w_h0;
    logic [23:0] w_wb0;
    logic [1:0]  w_pos0;
    logic        w_acc;

    mm2_mul u_mul (
        .i_op   (w_op),
        .i_h    (r_h),
        .i_k    (r_k),
        .i_wb   (r_wb),
        .o_prod (w_prod)
    );

    assign o_ready = (r_state == mm2_pkg::ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_hash  = r_hash;
    assign w_acc   = i_valid && o_ready;

    assign w_h0   = i_first ? i_msg_len : r_h;
    assign w_wb0  = i_first ? 24'd0 : r_wb;
    assign w_pos0 = i_first ? 2'd0 : r_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mm2_pkg::ST_IDLE;
            r_h         <= '0;
            r_wb        <= '0;
            r_pos       <= '0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_h         <= n_h;
            r_wb        <= n_wb;
            r_pos       <= n_pos;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_hash <= n_hash;
    end

    always_comb begin
        n_state     = r_state;
        n_h         = r_h;
        n_k         = r_k;
        n_wb        = r_wb;
        n_pos       = r_pos;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_hash      = r_hash;
        w_op        = mm2_pkg::OP_KEY;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            mm2_pkg::ST_IDLE: begin
                if (w_acc) begin
                    n_h    = w_h0;
                    n_wb   = w_wb0;
                    n_pos  = w_pos0;
                    n_last = i_last;
                    if (i_empty_msg) begin
                        n_state = i_last ? mm2_pkg::ST_TAIL : mm2_pkg::ST_IDLE;
                    end else if (w_pos0 != 2'd3) begin
                        unique case (w_pos0)
                            2'd0:    n_wb = {w_wb0[23:8], i_data_byte};
                            2'd1:    n_wb = {w_wb0[23:16], i_data_byte, w_wb0[7:0]};
                            default: n_wb = {i_data_byte, w_wb0[15:0]};
                        endcase
                        n_pos   = w_pos0 + 2'd1;
                        n_state = i_last ? mm2_pkg::ST_TAIL : mm2_pkg::ST_IDLE;
                    end else begin
                        n_k     = {i_data_byte, w_wb0};
                        n_wb    = '0;
                        n_pos   = '0;
                        n_state = mm2_pkg::ST_K1;
                    end
                end
            end
            mm2_pkg::ST_K1: begin
                w_op    = mm2_pkg::OP_KEY;
                n_k     = w_prod ^ (w_prod >> mm2_pkg::SHR_R);
                n_state = mm2_pkg::ST_K2;
            end
            mm2_pkg::ST_K2: begin
                w_op    = mm2_pkg::OP_KEY;
                n_k     = w_prod;
                n_state = mm2_pkg::ST_H1;
            end
            mm2_pkg::ST_H1: begin
                w_op    = mm2_pkg::OP_HASH;
                n_h     = w_prod ^ r_k;
                n_state = r_last ? mm2_pkg::ST_TAIL : mm2_pkg::ST_IDLE;
            end
            mm2_pkg::ST_TAIL: begin
                w_op = mm2_pkg::OP_TAIL;
                if (r_pos != 2'd0) begin
                    n_h = w_prod;
                end
                n_state = mm2_pkg::ST_AVAL;
            end
            mm2_pkg::ST_AVAL: begin
                w_op    = mm2_pkg::OP_AVAL;
                n_h     = w_prod;
                n_state = mm2_pkg::ST_OUT;
            end
            mm2_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_hash      = r_h ^ (r_h >> mm2_pkg::SHR_F2);
                    n_out_valid = 1'b1;
                    n_h         = '0;
                    n_wb        = '0;
                    n_pos       = '0;
                    n_last      = 1'b0;
                    n_state     = mm2_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mm2_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_key_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mm2_pkg::ST_K1) |=> (r_state == mm2_pkg::ST_K2))
        else $error("key mix did not advance to second multiply");

    a_group_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mm2_pkg::ST_K1 || r_state == mm2_pkg::ST_K2)
        |-> (r_pos == 2'd0 && r_wb == 24'd0))
        else $error("byte buffer not cleared after full group");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_first && i_last && i_empty_msg && i_msg_len == 32'd0)
        |-> ##3 (r_state == mm2_pkg::ST_OUT && r_h == 32'd0))
        else $error("empty message does not hash to zero");

    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> ($past(r_state) == mm2_pkg::ST_OUT))
        else $error("result raised outside output step");
`endif

endmodule

/* hdl/mm2_mul.sv */
module mm2_mul (
    input  mm2_pkg::t_mul_op i_op,
    input  logic [31:0]      i_h,
    input  logic [31:0]      i_k,
    input  logic [23:0]      i_wb,
    output logic [31:0]      o_prod
);

    logic [31:0] w_opnd;

    always_comb begin
        unique case (i_op)
            mm2_pkg::OP_KEY:  w_opnd = i_k;
            mm2_pkg::OP_HASH: w_opnd = i_h;
            mm2_pkg::OP_TAIL: w_opnd = i_h ^ {8'd0, i_wb};
            mm2_pkg::OP_AVAL: w_opnd = i_h ^ (i_h >> mm2_pkg::SHR_F1);
            default:          w_opnd = i_h;
        endcase
    end

    assign o_prod = w_opnd * mm2_pkg::MUL;

endmodule
